/* design/psb_pkg.sv */
// Shared types and constants for the profile select button controller.
`default_nettype none
package psb_pkg;

   localparam int unsigned BUTTON_W          = 16;
   localparam int unsigned BUTTON_COUNT_DEF  = 16;
   localparam int unsigned TICKS_W           = 16;
   localparam int unsigned BLINKS_W          = 6;
   localparam int unsigned INDEX_W           = 4;
   localparam int unsigned CSR_ADDR_W        = 2;

   localparam logic [TICKS_W-1:0] LEAD_DELAY_RST   = 16'd15624;
   localparam logic [TICKS_W-1:0] BLINK_PERIOD_RST = 16'd3905;
   localparam logic [TICKS_W-1:0] TAIL_DELAY_RST   = 16'd15624;

   localparam logic [CSR_ADDR_W-1:0] CSR_LEAD_DELAY   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLINK_PERIOD = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TAIL_DELAY   = 2'd2;

   typedef enum logic [2:0] {
      PH_ALLOWED = 3'd0,
      PH_LOCKED  = 3'd1,
      PH_ARMED   = 3'd2,
      PH_LEAD    = 3'd3,
      PH_BLINK   = 3'd4,
      PH_TAIL    = 3'd5
   } phase_type;

   typedef struct packed {
      logic                mode_pressed;
      logic [BUTTON_W-1:0] buttons;
      logic                tick;
   } req_payload_type;

   typedef struct packed {
      logic               led_on;
      logic               load_profile;
      logic [INDEX_W-1:0] profile_index;
      logic [2:0]         phase;
   } rsp_payload_type;

   typedef struct packed {
      logic [TICKS_W-1:0] lead_delay_ticks;
      logic [TICKS_W-1:0] blink_period_ticks;
      logic [TICKS_W-1:0] tail_delay_ticks;
   } cfg_type;

endpackage
`default_nettype wire

/* design/psb_csr.sv */
// Timer compare configuration registers.
`default_nettype none
module psb_csr
   import psb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [TICKS_W-1:0]    csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_index)
            CSR_LEAD_DELAY:   cfg_in.lead_delay_ticks   = csr_data;
            CSR_BLINK_PERIOD: cfg_in.blink_period_ticks = csr_data;
            CSR_TAIL_DELAY:   cfg_in.tail_delay_ticks   = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lead_delay_ticks   <= LEAD_DELAY_RST;
         cfg_ff.blink_period_ticks <= BLINK_PERIOD_RST;
         cfg_ff.tail_delay_ticks   <= TAIL_DELAY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* design/psb_ctrl.sv */
// Phase state machine, CTC timer and LED control; updates once per step.
`default_nettype none
module psb_ctrl
   import psb_pkg::*;
#(
   parameter int unsigned BUTTON_COUNT = BUTTON_COUNT_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      step,
   input  req_payload_type item,
   input  cfg_type        cfg,
   output rsp_payload_type result
);

   phase_type            phase_ff, phase_in, phase_a;
   logic [BLINKS_W-1:0]  blinks_ff, blinks_in, blinks_a, blinks_dec;
   logic [TICKS_W-1:0]   count_ff, count_in, count_t;
   logic [TICKS_W-1:0]   compare_ff, compare_in;
   logic                 flag_ff, flag_in, flag_t, flag_a;
   logic                 led_ff, led_in;

   logic [BUTTON_W-1:0]  mask;
   logic [BUTTON_W-1:0]  btn;
   logic                 any_btn;
   logic [INDEX_W-1:0]   low_idx;
   logic                 hit;
   logic                 select;
   logic                 load;

   always_comb begin
      for (int i = 0; i < BUTTON_W; i++) begin
         mask[i] = (i < BUTTON_COUNT);
      end
   end

   assign btn     = item.buttons & mask;
   assign any_btn = |btn;

   // lowest pressed button wins
   always_comb begin
      low_idx = '0;
      for (int i = BUTTON_W - 1; i >= 0; i--) begin
         if (btn[i]) begin
            low_idx = INDEX_W'(i);
         end
      end
   end

   // timer advances ahead of the phase logic
   assign hit     = item.tick && (count_ff == compare_ff);
   assign count_t = !item.tick ? count_ff : (hit ? '0 : count_ff + 1'b1);
   assign flag_t  = flag_ff || hit;

   assign select     = item.mode_pressed && (phase_ff == PH_ARMED) && any_btn;
   assign flag_a     = select ? 1'b0 : flag_t;
   assign blinks_a   = select ? ({1'b0, low_idx, 1'b0} + BLINKS_W'(2)) : blinks_ff;
   assign blinks_dec = blinks_a - 1'b1;

   // next state
   always_comb begin
      phase_a = phase_ff;
      if (item.mode_pressed) begin
         if (phase_ff == PH_ALLOWED) begin
            phase_a = any_btn ? PH_LOCKED : PH_ARMED;
         end else if (select) begin
            phase_a = PH_LEAD;
         end
      end else if (phase_ff != PH_BLINK && phase_ff != PH_LEAD && phase_ff != PH_TAIL) begin
         phase_a = PH_ALLOWED;
      end

      phase_in = phase_a;
      if (flag_a) begin
         unique case (phase_a)
            PH_LEAD:  phase_in = PH_BLINK;
            PH_BLINK: phase_in = (blinks_dec == '0) ? PH_TAIL : PH_BLINK;
            PH_TAIL:  phase_in = PH_LOCKED;
            default:  phase_in = phase_a;
         endcase
      end
   end

   // datapath and outputs
   always_comb begin
      count_in   = select ? '0 : count_t;
      compare_in = select ? cfg.lead_delay_ticks : compare_ff;
      flag_in    = flag_a;
      blinks_in  = blinks_a;
      led_in     = led_ff;
      load       = select;

      if (item.mode_pressed) begin
         if (phase_ff == PH_ALLOWED && !any_btn) begin
            led_in = 1'b0;
         end
      end else if (phase_ff != PH_BLINK && phase_ff != PH_LEAD && phase_ff != PH_TAIL) begin
         led_in = 1'b1;
      end

      if (flag_a) begin
         unique case (phase_a)
            PH_LEAD: begin
               flag_in    = 1'b0;
               compare_in = cfg.blink_period_ticks;
            end
            PH_BLINK: begin
               flag_in   = 1'b0;
               led_in    = ~led_in;
               blinks_in = blinks_dec;
               if (blinks_dec == '0) begin
                  compare_in = cfg.tail_delay_ticks;
               end
            end
            PH_TAIL: begin
               flag_in = 1'b0;
               led_in  = 1'b1;
            end
            default: flag_in = flag_a;
         endcase
      end

      result.led_on        = led_in;
      result.load_profile  = load;
      result.profile_index = load ? low_idx : '0;
      result.phase         = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_ALLOWED;
         blinks_ff  <= '0;
         count_ff   <= '0;
         compare_ff <= '0;
         flag_ff    <= 1'b0;
         led_ff     <= 1'b1;
      end else if (step) begin
         phase_ff   <= phase_in;
         blinks_ff  <= blinks_in;
         count_ff   <= count_in;
         compare_ff <= compare_in;
         flag_ff    <= flag_in;
         led_ff     <= led_in;
      end
   end

`ifndef SYNTHESIS
   a_select_starts_lead: assert property (@(posedge clock) disable iff (reset)
      (step && select) |=> (phase_ff == PH_LEAD && count_ff == '0 && !flag_ff))
      else $error("profile select did not start a clean lead wait");

   a_blink_count_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BLINK) |-> (blinks_ff != '0))
      else $error("blinking with no blinks left");

   a_armed_led_off: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ARMED) |-> !led_ff)
      else $error("LED on while armed");

   a_idle_led_on: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ALLOWED || phase_ff == PH_LOCKED) |-> led_ff)
      else $error("LED off while allowed or locked");
`endif

endmodule
`default_nettype wire

/* design/profile_select_button_fsm_top.sv */
// Top level of the profile select button controller.
// One poll transaction in, one result transaction out. A transaction is
// registered on acceptance, processed by the state update once the result
// register is free and held there until taken, so a new poll can be
// accepted every cycle while the result side keeps up; a stalled result
// holds one poll in the input register. The three timer compare registers
// (lead delay, blink period, tail delay) are written through the csr_ port,
// by the user only while the block is idle (the block does not enforce
// this), and take effect the next time the timer loads that compare value.
`default_nettype none
module profile_select_button_fsm_top
   import psb_pkg::*;
#(
   parameter int unsigned BUTTON_COUNT = BUTTON_COUNT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  req_payload_type            req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_payload_type            rsp_payload,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [TICKS_W-1:0]    csr_data
);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type result;
   cfg_type         cfg;
   logic            advance;
   logic            step;
   logic            take;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = step ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   psb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   psb_ctrl #(
      .BUTTON_COUNT (BUTTON_COUNT)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_payload;
      end
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule
`default_nettype wire

/* bench/psb_checker.sv */
// Transaction checker for the profile select controller: predicts each poll and compares results.
module psb_checker
   import psb_pkg::*;
#(
   parameter int unsigned BUTTON_COUNT = BUTTON_COUNT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  req_payload_type            req_payload,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  rsp_payload_type            rsp_payload,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [TICKS_W-1:0]    csr_data,
   output int unsigned                pending,
   output int unsigned                mismatches
);

   localparam logic [BUTTON_W-1:0] PAD_MASK = (BUTTON_COUNT >= BUTTON_W) ? '1 :
                                              BUTTON_W'((32'd1 << BUTTON_COUNT) - 1);

   cfg_type            timer_cfg;
   phase_type          ph;
   logic [BLINKS_W-1:0] blinks_left;
   logic [TICKS_W-1:0] tmr_count;
   logic [TICKS_W-1:0] tmr_cmp;
   logic               tmr_match;
   logic               led;

   rsp_payload_type    expected_q[$];
   rsp_payload_type    want;
   int unsigned        errs = 0;

   function automatic rsp_payload_type poll_step(input req_payload_type p);
      logic [BUTTON_W-1:0] pads;
      int unsigned         slot;
      rsp_payload_type     r;
      pads = p.buttons & PAD_MASK;
      r = '0;
      // timer runs ahead of the phase logic in the same poll
      if (p.tick) begin
         if (tmr_count == tmr_cmp) begin
            tmr_count = '0;
            tmr_match = 1'b1;
         end else begin
            tmr_count = tmr_count + 1'b1;
         end
      end
      if (p.mode_pressed) begin
         if (ph == PH_ALLOWED) begin
            if (pads != '0) begin
               ph = PH_LOCKED;
            end else begin
               ph = PH_ARMED;
               led = 1'b0;
            end
         end else if (ph == PH_ARMED && pads != '0) begin
            slot = 0;
            while (slot < 15 && !pads[slot]) slot++;
            ph = PH_LEAD;
            tmr_count = '0;
            tmr_match = 1'b0;
            tmr_cmp = timer_cfg.lead_delay_ticks;
            r.load_profile = 1'b1;
            r.profile_index = slot[INDEX_W-1:0];
            blinks_left = BLINKS_W'(2 * (slot + 1));
         end
      end else if (ph != PH_BLINK && ph != PH_LEAD && ph != PH_TAIL) begin
         ph = PH_ALLOWED;
         led = 1'b1;
      end
      case (ph)
         PH_BLINK: if (tmr_match) begin
            tmr_match = 1'b0;
            led = ~led;
            blinks_left = blinks_left - 1'b1;
            if (blinks_left == '0) begin
               tmr_cmp = timer_cfg.tail_delay_ticks;
               ph = PH_TAIL;
            end
         end
         PH_LEAD: if (tmr_match) begin
            tmr_match = 1'b0;
            tmr_cmp = timer_cfg.blink_period_ticks;
            ph = PH_BLINK;
         end
         PH_TAIL: if (tmr_match) begin
            tmr_match = 1'b0;
            ph = PH_LOCKED;
            led = 1'b1;
         end
         default: ;
      endcase
      r.led_on = led;
      r.phase = ph;
      return r;
   endfunction

   task automatic check_field(input string what, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         errs++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ph = PH_ALLOWED;
         blinks_left = '0;
         tmr_count = '0;
         tmr_cmp = '0;
         tmr_match = 1'b0;
         led = 1'b1;
         timer_cfg = '{LEAD_DELAY_RST, BLINK_PERIOD_RST, TAIL_DELAY_RST};
         expected_q.delete();
         errs = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               errs++;
               $display("%0t: unexpected result transaction, expected none, actual %p",
                        $time, rsp_payload);
            end else begin
               want = expected_q.pop_front();
               check_field("led_on", 32'(want.led_on), 32'(rsp_payload.led_on));
               check_field("load_profile", 32'(want.load_profile),
                           32'(rsp_payload.load_profile));
               check_field("profile_index", 32'(want.profile_index),
                           32'(rsp_payload.profile_index));
               check_field("phase", 32'(want.phase), 32'(rsp_payload.phase));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LEAD_DELAY:   timer_cfg.lead_delay_ticks = csr_data;
               CSR_BLINK_PERIOD: timer_cfg.blink_period_ticks = csr_data;
               CSR_TAIL_DELAY:   timer_cfg.tail_delay_ticks = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_q.push_back(poll_step(req_payload));
      end
      pending <= expected_q.size();
      mismatches <= errs;
   end

endmodule

/* bench/profile_select_button_fsm_top_tb.sv */
// Testbench top for the profile select controller: stimulus, flow control and verdict.
module profile_select_button_fsm_top_tb
   import psb_pkg::*;
();

   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED   = 2'd3;
   localparam int unsigned           CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned           RANDOM_POLLS = 1300;
   localparam int unsigned           SETTINGS_RUNS = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   rsp_payload_type       rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [TICKS_W-1:0]    csr_data = '0;
   int unsigned           pending;
   int unsigned           mismatches;

   // local copy of the timer settings, for sizing sessions and the final flush
   cfg_type     timer_cfg = '{LEAD_DELAY_RST, BLINK_PERIOD_RST, TAIL_DELAY_RST};
   bit          no_gaps = 1'b0;
   int unsigned polls_sent = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;

   profile_select_button_fsm_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   psb_checker profile_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .pending     (pending),
      .mismatches  (mismatches)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [TICKS_W-1:0] pick_ticks(input int unsigned ceiling);
      if ($urandom_range(0, 9) < 7) return TICKS_W'($urandom_range(0, 3));
      return TICKS_W'($urandom_range(0, ceiling));
   endfunction

   always @(posedge clock) begin
      if (no_gaps || stall_left == 0) begin
         rsp_ready <= 1'b1;
         if (!no_gaps && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end else begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end
   end

   task automatic send_poll(input logic mode, input logic [BUTTON_W-1:0] pads,
                            input logic tick);
      int unsigned     gap;
      req_payload_type p;
      gap = no_gaps ? 0 : pick_gap();
      p.mode_pressed = mode;
      p.buttons = pads;
      p.tick = tick;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      polls_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic csr_put(input logic [CSR_ADDR_W-1:0] idx, input logic [TICKS_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // call only with nothing outstanding
   task automatic program_timer(input logic [TICKS_W-1:0] lead, input logic [TICKS_W-1:0] blink,
                                input logic [TICKS_W-1:0] tail);
      csr_put(CSR_UNUSED, TICKS_W'($urandom));
      csr_put(CSR_LEAD_DELAY, lead);
      csr_put(CSR_BLINK_PERIOD, blink);
      csr_put(CSR_TAIL_DELAY, tail);
      csr_valid <= 1'b0;
      timer_cfg = '{lead, blink, tail};
   endtask

   // arm, select profile 'slot', then feed enough ticks to run lead, blinks and tail
   task automatic profile_session(input int unsigned slot, input bit steady);
      logic [BUTTON_W-1:0] pads;
      int unsigned         needed;
      int unsigned         sent;
      logic                tick;
      pads = (BUTTON_W'($urandom) | 1'b1) << slot;
      needed = (timer_cfg.lead_delay_ticks + 1) + (timer_cfg.tail_delay_ticks + 1) +
               2 * (slot + 1) * (timer_cfg.blink_period_ticks + 1);
      send_poll(1'b1, '0, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 2)) send_poll(1'b1, '0, 1'($urandom_range(0, 1)));
      send_poll(1'b1, pads, 1'($urandom_range(0, 1)));
      sent = 0;
      while (sent < needed) begin
         tick = steady || $urandom_range(0, 3) != 0;
         send_poll(steady || $urandom_range(0, 3) != 0,
                   steady ? '0 : BUTTON_W'($urandom), tick);
         if (tick) sent++;
      end
      repeat ($urandom_range(0, 2))
         send_poll(1'b1, BUTTON_W'($urandom), 1'($urandom_range(0, 1)));
      send_poll(1'b0, BUTTON_W'($urandom), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int unsigned run_end;
      int unsigned slot;
      int unsigned flush;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset timer settings: lock, hold, release, arm, release
      send_poll(1'b0, '0, 1'b1);
      send_poll(1'b1, '1, 1'b0);
      send_poll(1'b1, '0, 1'b1);
      send_poll(1'b0, '1, 1'b0);
      send_poll(1'b1, '0, 1'b1);
      send_poll(1'b0, '0, 1'b0);
      drain();

      // zero compare values: highest profile, mode released and pressed mid-run
      program_timer('0, '0, '0);
      send_poll(1'b1, '0, 1'b0);
      send_poll(1'b1, 16'h8000, 1'b1);
      send_poll(1'b0, '0, 1'b1);
      send_poll(1'b0, '0, 1'b1);
      send_poll(1'b1, '1, 1'b0);
      send_poll(1'b0, 16'h5555, 1'b1);

      for (int unsigned run = 0; run < SETTINGS_RUNS; run++) begin
         drain();
         program_timer(pick_ticks(20), pick_ticks(6), pick_ticks(20));
         no_gaps = (run == 3);
         run_end = polls_sent + RANDOM_POLLS / SETTINGS_RUNS;
         while (polls_sent < run_end) begin
            if ($urandom_range(0, 3) != 0) begin
               slot = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 15);
               profile_session(slot, 1'b0);
            end else begin
               repeat ($urandom_range(1, 8))
                  send_poll(1'($urandom_range(0, 1)),
                            $urandom_range(0, 1) ? BUTTON_W'($urandom) : '0,
                            1'($urandom_range(0, 1)));
            end
         end
      end

      // let any timed phase left by noise run out, then load the largest compare values
      // and start a lead wait on the highest profile
      flush = (timer_cfg.lead_delay_ticks + 1) + (timer_cfg.tail_delay_ticks + 1) +
              32 * (timer_cfg.blink_period_ticks + 1);
      repeat (flush) send_poll(1'b0, BUTTON_W'($urandom), 1'b1);
      drain();
      program_timer('1, '1, '1);
      no_gaps = 1'b1;
      send_poll(1'b0, '0, 1'b1);
      send_poll(1'b1, '0, 1'b1);
      send_poll(1'b1, 16'h8000, 1'b1);
      repeat (24) send_poll(1'b0, BUTTON_W'($urandom), 1'b1);
      drain();

      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
